FILE: sv/sera_pkg.sv
// Shared types and constants for the sonar echo ranger averager.
// Used by sera_ctrl, sera_datapath and the top level; depends on nothing.
package sera_pkg;

   // Fixed sizes of the burst logic.
   localparam int MAX_READINGS = 16;
   localparam int WIDTH_BITS   = 16;
   localparam int TICK_W       = 17;
   localparam int INDEX_W      = 5;
   localparam int TOTAL_W      = 20;
   localparam int DIVISOR_W    = 5;
   localparam int DIV_STEPS    = TOTAL_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   // Configuration port sizes.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_READINGS_PER_BURST   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_WIDTH        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_START_TIMEOUT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_PULSE_TIMEOUT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_WIDTH_THRESHOLD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_GAP             = 3'd5;

   // Configuration reset values.
   localparam logic [4:0]  RST_READINGS_PER_BURST   = 5'd5;
   localparam logic [7:0]  RST_TRIGGER_WIDTH        = 8'd10;
   localparam logic [15:0] RST_ECHO_START_TIMEOUT   = 16'd5000;
   localparam logic [15:0] RST_ECHO_PULSE_TIMEOUT   = 16'd60000;
   localparam logic [15:0] RST_SAFE_WIDTH_THRESHOLD = 16'd1000;
   localparam logic [16:0] RST_IDLE_GAP             = 17'd100000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic step;      // accept one tick beat
      logic div_step;  // one bit of the average divide
      logic publish;   // load the finished average into the output register
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic needs_div; // the offered tick ends a burst with valid readings
      logic rsp_full;  // the output register holds a beat
   } dp_status_type;

endpackage

FILE: sv/sera_datapath.sv
// Datapath of the sonar echo ranger averager: configuration registers, reading
// state, bit-serial average divider and output register. Depends on sera_pkg.
module sera_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sera_pkg::ctl_cmd_type             cmd,
   output sera_pkg::dp_status_type           status,
   input  logic                              csr_we,
   input  logic [sera_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sera_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_echo_level,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_trigger_out,
   output logic                              rsp_warning_led,
   output logic                              rsp_result_strobe,
   output logic [sera_pkg::WIDTH_BITS-1:0]   rsp_average_width,
   output logic                              rsp_no_reading
);
   import sera_pkg::*;

   typedef enum logic [1:0] {
      PH_TRIG,
      PH_RISE,
      PH_HIGH,
      PH_IDLE
   } phase_type;

   // Configuration registers.
   logic [4:0]  readings_per_burst_ff;
   logic [7:0]  trigger_width_ff;
   logic [15:0] echo_start_timeout_ff;
   logic [15:0] echo_pulse_timeout_ff;
   logic [15:0] safe_width_threshold_ff;
   logic [16:0] idle_gap_ff;

   // Reading state.
   phase_type              phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [INDEX_W-1:0]     index_ff, index_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [DIVISOR_W-1:0]   vcount_ff, vcount_in;
   logic                   led_ff, led_in;
   logic [WIDTH_BITS-1:0]  held_ff, held_in;

   // Divider registers.
   logic [TOTAL_W-1:0]     quot_ff;
   logic [DIVISOR_W-1:0]   rem_ff;
   logic [DIVISOR_W-1:0]   divisor_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_trig_ff;
   logic                   rsp_led_ff;
   logic                   rsp_strobe_ff;
   logic [WIDTH_BITS-1:0]  rsp_avg_ff;
   logic                   rsp_none_ff;

   // Combinational step results.
   logic [7:0]             trig_len;
   logic [15:0]            rise_len;
   logic [INDEX_W-1:0]     count_lim;
   logic [TICK_W-1:0]      tick_inc;
   logic [INDEX_W-1:0]     index_inc;
   logic [TOTAL_W-1:0]     total_acc;
   logic [DIVISOR_W-1:0]   vcount_acc;
   logic                   trig;
   logic                   reading_done;
   logic                   burst_end;
   logic                   none;
   logic                   needs_div;

   // Divider step and finished average.
   logic [DIVISOR_W:0]     rem_shift;
   logic                   quot_bit;
   logic [DIVISOR_W-1:0]   rem_next;
   logic [WIDTH_BITS-1:0]  avg_new;
   logic                   led_new;

   // Effective settings: zero widths act as one, reading count is clamped.
   assign trig_len = (trigger_width_ff == 8'd0) ? 8'd1 : trigger_width_ff;
   assign rise_len = (echo_start_timeout_ff == 16'd0) ? 16'd1 : echo_start_timeout_ff;
   always_comb begin
      if (readings_per_burst_ff == '0) begin
         count_lim = INDEX_W'(1);
      end else if (readings_per_burst_ff > INDEX_W'(MAX_READINGS)) begin
         count_lim = INDEX_W'(MAX_READINGS);
      end else begin
         count_lim = readings_per_burst_ff;
      end
   end

   assign tick_inc  = tick_ff + TICK_W'(1);
   assign index_inc = index_ff + INDEX_W'(1);

   // Next reading state for one tick.
   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      index_in     = index_ff;
      total_acc    = total_ff;
      vcount_acc   = vcount_ff;
      trig         = 1'b0;
      reading_done = 1'b0;
      burst_end    = 1'b0;
      none         = 1'b0;
      needs_div    = 1'b0;
      case (phase_ff)
         PH_TRIG: begin
            trig    = 1'b1;
            tick_in = tick_inc;
            if (tick_inc >= TICK_W'(trig_len)) begin
               phase_in = PH_RISE;
               tick_in  = '0;
            end
         end
         PH_RISE: begin
            if (req_echo_level) begin
               phase_in = PH_HIGH;
               tick_in  = TICK_W'(1);
               if (echo_pulse_timeout_ff == 16'd0) begin
                  reading_done = 1'b1;
               end
            end else begin
               tick_in = tick_inc;
               if (tick_inc >= TICK_W'(rise_len)) begin
                  reading_done = 1'b1;
               end
            end
         end
         PH_HIGH: begin
            if (!req_echo_level) begin
               total_acc    = total_ff + TOTAL_W'(tick_ff);
               vcount_acc   = vcount_ff + DIVISOR_W'(1);
               reading_done = 1'b1;
            end else begin
               tick_in = tick_inc;
               if (tick_inc > TICK_W'(echo_pulse_timeout_ff)) begin
                  reading_done = 1'b1;
               end
            end
         end
         PH_IDLE: begin
            tick_in = tick_inc;
            if (tick_inc >= idle_gap_ff) begin
               phase_in = PH_TRIG;
               tick_in  = '0;
               index_in = '0;
               total_acc  = '0;
               vcount_acc = '0;
            end
         end
         default: begin
            phase_in = PH_TRIG;
         end
      endcase

      total_in  = total_acc;
      vcount_in = vcount_acc;
      if (reading_done) begin
         index_in = index_inc;
         tick_in  = '0;
         phase_in = PH_TRIG;
         if (index_inc >= count_lim) begin
            burst_end = 1'b1;
            none      = (vcount_acc == '0);
            needs_div = (vcount_acc != '0);
            index_in  = '0;
            total_in  = '0;
            vcount_in = '0;
            phase_in  = (idle_gap_ff == '0) ? PH_TRIG : PH_IDLE;
         end
      end
   end

   // One restoring divide step; the remainder stays below the divisor.
   assign rem_shift = {rem_ff, quot_ff[TOTAL_W-1]};
   assign quot_bit  = (rem_shift >= {1'b0, divisor_ff});
   assign rem_next  = quot_bit ? DIVISOR_W'(rem_shift - {1'b0, divisor_ff})
                               : rem_shift[DIVISOR_W-1:0];
   assign avg_new   = quot_ff[WIDTH_BITS-1:0];
   assign led_new   = (avg_new < safe_width_threshold_ff);

   assign led_in  = cmd.publish ? led_new : led_ff;
   assign held_in = cmd.publish ? avg_new : held_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         readings_per_burst_ff   <= RST_READINGS_PER_BURST;
         trigger_width_ff        <= RST_TRIGGER_WIDTH;
         echo_start_timeout_ff   <= RST_ECHO_START_TIMEOUT;
         echo_pulse_timeout_ff   <= RST_ECHO_PULSE_TIMEOUT;
         safe_width_threshold_ff <= RST_SAFE_WIDTH_THRESHOLD;
         idle_gap_ff             <= RST_IDLE_GAP;
      end else if (csr_we) begin
         case (csr_index)
            CSR_READINGS_PER_BURST:   readings_per_burst_ff   <= csr_wdata[4:0];
            CSR_TRIGGER_WIDTH:        trigger_width_ff        <= csr_wdata[7:0];
            CSR_ECHO_START_TIMEOUT:   echo_start_timeout_ff   <= csr_wdata[15:0];
            CSR_ECHO_PULSE_TIMEOUT:   echo_pulse_timeout_ff   <= csr_wdata[15:0];
            CSR_SAFE_WIDTH_THRESHOLD: safe_width_threshold_ff <= csr_wdata[15:0];
            CSR_IDLE_GAP:             idle_gap_ff             <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Reading state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TRIG;
         tick_ff   <= '0;
         index_ff  <= '0;
         total_ff  <= '0;
         vcount_ff <= '0;
         led_ff    <= 1'b0;
         held_ff   <= '0;
      end else begin
         if (cmd.step) begin
            phase_ff  <= phase_in;
            tick_ff   <= tick_in;
            index_ff  <= index_in;
            total_ff  <= total_in;
            vcount_ff <= vcount_in;
         end
         led_ff  <= led_in;
         held_ff <= held_in;
      end
   end

   // Divider: loaded at a burst end with valid readings, then one bit a cycle.
   always_ff @(posedge clock) begin
      if (cmd.step && needs_div) begin
         quot_ff    <= total_acc;
         rem_ff     <= '0;
         divisor_ff <= vcount_acc;
      end else if (cmd.div_step) begin
         quot_ff <= {quot_ff[TOTAL_W-2:0], quot_bit};
         rem_ff  <= rem_next;
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.step && !needs_div) || cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.step && !needs_div) begin
         rsp_trig_ff   <= trig;
         rsp_led_ff    <= led_ff;
         rsp_strobe_ff <= 1'b0;
         rsp_avg_ff    <= held_ff;
         rsp_none_ff   <= none && burst_end;
      end else if (cmd.publish) begin
         rsp_trig_ff   <= 1'b0;
         rsp_led_ff    <= led_new;
         rsp_strobe_ff <= 1'b1;
         rsp_avg_ff    <= avg_new;
         rsp_none_ff   <= 1'b0;
      end
   end

   assign status.needs_div = needs_div;
   assign status.rsp_full  = rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trigger_out   = rsp_trig_ff;
   assign rsp_warning_led   = rsp_led_ff;
   assign rsp_result_strobe = rsp_strobe_ff;
   assign rsp_average_width = rsp_avg_ff;
   assign rsp_no_reading    = rsp_none_ff;

endmodule

FILE: sv/sera_ctrl.sv
// Controller of the sonar echo ranger averager: accepts tick beats and
// sequences the average divide. Depends on sera_pkg.
module sera_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     rsp_ready,
   input  sera_pkg::dp_status_type  status,
   output sera_pkg::ctl_cmd_type    cmd
);
   import sera_pkg::*;

   typedef enum logic [1:0] {
      S_RUN,
      S_DIV,
      S_PUB
   } state_type;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  div_count_ff, div_count_in;
   logic                  accept;

   // A beat is taken when running and the output register is free or draining.
   assign req_ready = (state_ff == S_RUN) && (!status.rsp_full || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign cmd.step     = accept;
   assign cmd.div_step = (state_ff == S_DIV);
   assign cmd.publish  = (state_ff == S_PUB);

   // Next state.
   always_comb begin
      state_in     = state_ff;
      div_count_in = div_count_ff;
      case (state_ff)
         S_RUN: begin
            div_count_in = '0;
            if (accept && status.needs_div) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            div_count_in = div_count_ff + DIV_CNT_W'(1);
            if (div_count_ff == DIV_LAST) begin
               state_in     = S_PUB;
               div_count_in = '0;
            end
         end
         S_PUB: begin
            state_in = S_RUN;
         end
         default: begin
            state_in     = S_RUN;
            div_count_in = '0;
         end
      endcase
   end

   // State and divide step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         div_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         div_count_ff <= div_count_in;
      end
   end

   // No beat is taken while the divider is busy or publishing.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RUN) |-> !req_ready)
      else $error("beat taken while divide in progress");

   // The divide runs exactly its step count and then publishes.
   a_div_to_pub: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_count_ff == DIV_LAST) |=> (state_ff == S_PUB))
      else $error("divide did not finish into publish");

   // A burst-end beat with valid readings starts the divide.
   a_start_div: assert property (@(posedge clock) disable iff (reset)
      (accept && status.needs_div) |=> (state_ff == S_DIV && div_count_ff == '0))
      else $error("divide not started at burst end");

   // The output register is empty when the average is published.
   a_pub_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUB) |-> !status.rsp_full)
      else $error("publish would overwrite a pending beat");

endmodule

FILE: sv/sonar_echo_ranger_averager_unit.sv
// Top level of the sonar echo ranger averager: controller plus datapath.
// Depends on sera_pkg, sera_ctrl and sera_datapath.
//
// Each req beat is one microsecond tick carrying the sampled echo level, and
// each one yields exactly one rsp beat with the trigger drive, LED drive,
// result strobe, last average and no-reading flag for that tick. The block
// takes one beat per clock cycle while rsp_ready keeps up and no divide runs.
// The beat that ends a burst with at least one valid reading is taken, then
// the bit-serial divide of the 20-bit width total by the valid count runs
// (one quotient bit a cycle), and then the average is published. Configuration
// writes take effect on the next beat; the user must make them only while the
// block is idle; the block does not check it. There is no reset clearing pass.
module sonar_echo_ranger_averager_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_echo_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_trigger_out,
   output logic                              rsp_warning_led,
   output logic                              rsp_result_strobe,
   output logic [sera_pkg::WIDTH_BITS-1:0]   rsp_average_width,
   output logic                              rsp_no_reading,
   input  logic                              csr_we,
   input  logic [sera_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sera_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sera_pkg::*;

   ctl_cmd_type    cmd;
   dp_status_type  status;

   // Handshake and divide sequencing.
   sera_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Reading state, divider and output register.
   sera_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_echo_level    (req_echo_level),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_trigger_out   (rsp_trigger_out),
      .rsp_warning_led   (rsp_warning_led),
      .rsp_result_strobe (rsp_result_strobe),
      .rsp_average_width (rsp_average_width),
      .rsp_no_reading    (rsp_no_reading)
   );

endmodule
